@@ hdl/iph_pkg.sv @@
package iph_pkg;

    localparam int FRAME_COUNT_DEF = 4096;
    localparam int AGE_BITS_DEF    = 8;
    localparam int COUNT_BITS_DEF  = 32;
    localparam int MAX_ORDER_DEF   = 9;

    localparam int N_TYPES    = 16;
    localparam int N_BUCKETS  = 8;
    localparam int HIST_DEPTH = N_TYPES * N_BUCKETS;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    localparam int OPCODE_W  = 2;
    localparam int INDEX_W   = 12;
    localparam int KIND_W    = 4;
    localparam int ORDER_W   = 4;
    localparam int BUCKET_W  = 3;
    localparam int ROUND_W   = 3;
    localparam int OUT_AGE_W = 8;
    localparam int COVER_W   = 10;
    localparam int STAT_W    = 32;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SCAN  = 2'd0,
        OP_ROUND = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_AGE,
        ST_BIN,
        ST_PUT
    } state_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [INDEX_W-1:0]  page_index;
        logic                page_valid;
        logic                on_lru;
        logic                idle_bit;
        logic                can_pin;
        logic                still_on_lru;
        logic                still_idle;
        logic [KIND_W-1:0]   page_kind;
        logic [ORDER_W-1:0]  huge_order;
        logic [BUCKET_W-1:0] stat_bucket;
    } item_t;

    typedef struct packed {
        logic [OUT_AGE_W-1:0] new_age;
        logic                 set_idle_request;
        logic [COVER_W-1:0]   pages_covered;
        logic                 counted;
        logic [BUCKET_W-1:0]  bucket_hit;
        logic [STAT_W-1:0]    stat_value;
    } res_t;

    localparam res_t RES_DEFAULT = '{
        new_age:          '0,
        set_idle_request: 1'b0,
        pages_covered:    COVER_W'(1),
        counted:          1'b0,
        bucket_hit:       '0,
        stat_value:       '0
    };

    localparam logic [15:0] BUCKET_START [N_BUCKETS] =
        '{16'd1, 16'd2, 16'd5, 16'd15, 16'd30, 16'd60, 16'd120, 16'd240};

    function automatic logic [BUCKET_W-1:0] bucket_of(input logic [15:0] age);
        logic [BUCKET_W-1:0] b;
        b = BUCKET_W'(N_BUCKETS - 1);
        for (int i = N_BUCKETS - 1; i >= 1; i--)
        begin
            if (age < BUCKET_START[i])
            begin
                b = BUCKET_W'(i - 1);
            end
        end
        return b;
    endfunction

    function automatic logic sample_hit(input logic [15:0] age, input logic [2:0] pr);
        logic hit;
        if (age == 16'd0)
        begin
            hit = pr[0];
        end
        else if (age < 16'd4)
        begin
            hit = 1'b1;
        end
        else if (age < 16'd8)
        begin
            hit = pr[0];
        end
        else if (age < 16'd16)
        begin
            hit = &pr[1:0];
        end
        else
        begin
            hit = &pr;
        end
        return hit;
    endfunction

endpackage

@@ hdl/iph_cmd_if.sv @@
interface iph_cmd_if
    import iph_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [INDEX_W-1:0]  page_index;
    logic                page_valid;
    logic                on_lru;
    logic                idle_bit;
    logic                can_pin;
    logic                still_on_lru;
    logic                still_idle;
    logic [KIND_W-1:0]   page_kind;
    logic [ORDER_W-1:0]  huge_order;
    logic [BUCKET_W-1:0] stat_bucket;

    modport source (
        output valid, opcode, page_index, page_valid, on_lru, idle_bit, can_pin,
               still_on_lru, still_idle, page_kind, huge_order, stat_bucket,
        input  ready
    );

    modport sink (
        input  valid, opcode, page_index, page_valid, on_lru, idle_bit, can_pin,
               still_on_lru, still_idle, page_kind, huge_order, stat_bucket,
        output ready
    );
endinterface

@@ hdl/iph_res_if.sv @@
interface iph_res_if
    import iph_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [OUT_AGE_W-1:0] new_age;
    logic                 set_idle_request;
    logic [COVER_W-1:0]   pages_covered;
    logic                 counted;
    logic [BUCKET_W-1:0]  bucket_hit;
    logic [STAT_W-1:0]    stat_value;

    modport source (
        output valid, new_age, set_idle_request, pages_covered, counted, bucket_hit,
               stat_value,
        input  ready
    );

    modport sink (
        input  valid, new_age, set_idle_request, pages_covered, counted, bucket_hit,
               stat_value,
        output ready
    );
endinterface

@@ hdl/idle_page_age_histogram.sv @@
// Idle page age histogram.
// cmd carries one item per page frame (scan), or a new-round, bin-read or
// age-clear command; res returns exactly one item for each accepted cmd item.
// Both channels move an item on a clock edge with valid and ready high.
// Page ages live in a FRAME_COUNT-deep memory, histogram bins in a 128-deep
// memory, each with one registered read port. A scan of a page in range reads
// its age entry and, if the page is valid, writes it back; a counted scan also
// reads and writes back one bin. A bin read only reads a bin, an age clear only
// writes an age entry. A new round or age clear goes straight to ST_PUT; a scan
// passes through ST_AGE (age read), a bin read through ST_BIN, and a counting
// scan through ST_AGE then ST_BIN (age read, then bin read). ST_PUT loads the
// output register; the next item is taken only once the current one is in it.
// After rst_n the age memory is cleared one entry per cycle, with cmd.ready
// low until every entry is cleared. Bins and the round counter clear at once.
// A stalled res holds its item in the output register; one finished item
// more waits in the block, and cmd.ready stays low until it can move on.
module idle_page_age_histogram
    import iph_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int AGE_BITS    = AGE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int MAX_ORDER   = MAX_ORDER_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    iph_cmd_if.sink     cmd,
    iph_res_if.source   res
);

    localparam int AW    = $clog2(FRAME_COUNT);
    localparam int ORD_W = 5;
    localparam int NW    = 20;
    localparam int SW    = ((COUNT_BITS > NW) ? COUNT_BITS : NW) + 1;
    localparam logic [SW-1:0] BIN_MAX = (SW'(1) << COUNT_BITS) - SW'(1);
    localparam logic [63:0]   STAT_MAX = 64'hFFFF_FFFF;

    logic [AGE_BITS-1:0]   age_mem  [FRAME_COUNT];
    logic [COUNT_BITS-1:0] hist_mem [HIST_DEPTH];

    state_t                state_reg, state_next;
    item_t                 item_reg, item_next;
    res_t                  res_reg, res_next;
    res_t                  out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;
    logic [ROUND_W-1:0]    round_reg, round_next;
    logic [HIST_DEPTH-1:0] hist_vld_reg, hist_vld_next;
    logic [AW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [HIST_AW-1:0]    hist_idx_reg, hist_idx_next;
    logic [AGE_BITS-1:0]   age_rd_reg;
    logic [COUNT_BITS-1:0] hist_rd_reg;

    logic                  age_we, age_re;
    logic [AW-1:0]         age_wa, age_ra;
    logic [AGE_BITS-1:0]   age_wd;
    logic                  hist_we, hist_re;
    logic [HIST_AW-1:0]    hist_ra;
    logic [COUNT_BITS-1:0] hist_wd;

    logic                  cmd_ready;
    logic                  cmd_in_range, item_in_range;
    logic [ORD_W-1:0]      order_sat;
    logic [NW-1:0]         cover_full;
    logic [2:0]            pr;
    logic                  smp;
    logic [AGE_BITS-1:0]   age_inc;
    logic [BUCKET_W-1:0]   bucket;
    logic [COUNT_BITS-1:0] bin;
    logic [SW-1:0]         bin_sum;
    logic [63:0]           bin_wide;

    assign cmd_in_range  = 32'(cmd.page_index) < 32'(FRAME_COUNT);
    assign item_in_range = 32'(item_reg.page_index) < 32'(FRAME_COUNT);
    assign order_sat     = (ORD_W'(item_reg.huge_order) > ORD_W'(MAX_ORDER))
                         ? ORD_W'(MAX_ORDER) : ORD_W'(item_reg.huge_order);
    assign cover_full    = NW'(1) << order_sat;
    assign pr            = 3'(item_reg.page_index >> order_sat) + round_reg;
    assign smp           = sample_hit(16'(age_rd_reg), pr);
    assign age_inc       = (age_rd_reg == '1) ? age_rd_reg : age_rd_reg + AGE_BITS'(1);
    assign bucket        = bucket_of(16'(age_inc));
    assign bin           = hist_vld_reg[hist_idx_reg] ? hist_rd_reg : '0;
    assign bin_sum       = SW'(bin) + SW'(cover_full);
    assign bin_wide      = 64'(bin);

    assign cmd_ready = (state_reg == ST_IDLE);
    assign cmd.ready = cmd_ready;

    always_ff @(posedge clk)
    begin
        if (age_we)
        begin
            age_mem[age_wa] <= age_wd;
        end
        if (age_re)
        begin
            age_rd_reg <= age_mem[age_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_idx_reg] <= hist_wd;
        end
        if (hist_re)
        begin
            hist_rd_reg <= hist_mem[hist_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
            round_reg     <= '0;
            hist_vld_reg  <= '0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            round_reg     <= round_next;
            hist_vld_reg  <= hist_vld_next;
            clr_cnt_reg   <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
        hist_idx_reg <= hist_idx_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !res.ready;
        round_next     = round_reg;
        hist_vld_next  = hist_vld_reg;
        clr_cnt_next   = clr_cnt_reg;
        hist_idx_next  = hist_idx_reg;
        age_we         = 1'b0;
        age_wa         = AW'(item_reg.page_index);
        age_wd         = '0;
        age_re         = 1'b0;
        age_ra         = AW'(cmd.page_index);
        hist_we        = 1'b0;
        hist_wd        = '0;
        hist_re        = 1'b0;
        hist_ra        = HIST_AW'({cmd.page_kind, cmd.stat_bucket});

        unique case (state_reg)
            ST_CLEAR:
            begin
                age_we       = 1'b1;
                age_wa       = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(FRAME_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    item_next = '{
                        opcode:       cmd.opcode,
                        page_index:   cmd.page_index,
                        page_valid:   cmd.page_valid,
                        on_lru:       cmd.on_lru,
                        idle_bit:     cmd.idle_bit,
                        can_pin:      cmd.can_pin,
                        still_on_lru: cmd.still_on_lru,
                        still_idle:   cmd.still_idle,
                        page_kind:    cmd.page_kind,
                        huge_order:   cmd.huge_order,
                        stat_bucket:  cmd.stat_bucket
                    };
                    res_next = RES_DEFAULT;
                    unique case (op_t'(cmd.opcode))
                        OP_SCAN:
                        begin
                            age_re     = cmd_in_range;
                            state_next = ST_AGE;
                        end
                        OP_ROUND:
                        begin
                            hist_vld_next = '0;
                            round_next    = round_reg + ROUND_W'(1);
                            state_next    = ST_PUT;
                        end
                        OP_READ:
                        begin
                            hist_re       = 1'b1;
                            hist_idx_next = hist_ra;
                            state_next    = ST_BIN;
                        end
                        OP_CLEAR:
                        begin
                            age_we     = cmd_in_range;
                            age_wa     = AW'(cmd.page_index);
                            state_next = ST_PUT;
                        end
                        default:
                        begin
                            state_next = ST_PUT;
                        end
                    endcase
                end
            end

            ST_AGE:
            begin
                state_next = ST_PUT;
                if (item_reg.page_valid && item_in_range)
                begin
                    age_we = 1'b1;
                    if (item_reg.on_lru)
                    begin
                        if (item_reg.idle_bit && smp
                            && !(item_reg.can_pin && item_reg.still_on_lru))
                        begin
                            age_wd = '0;
                        end
                        else if (item_reg.idle_bit
                                 && (smp ? item_reg.still_idle : (age_rd_reg != '0)))
                        begin
                            age_wd                 = age_inc;
                            res_next.pages_covered = cover_full[COVER_W-1:0];
                            res_next.new_age       = OUT_AGE_W'(age_inc);
                            res_next.counted       = 1'b1;
                            res_next.bucket_hit    = bucket;
                            hist_re                = 1'b1;
                            hist_ra                = HIST_AW'({item_reg.page_kind, bucket});
                            hist_idx_next          = hist_ra;
                            state_next             = ST_BIN;
                        end
                        else
                        begin
                            res_next.pages_covered    = cover_full[COVER_W-1:0];
                            res_next.set_idle_request = item_reg.can_pin
                                                      && item_reg.still_on_lru;
                        end
                    end
                end
            end

            ST_BIN:
            begin
                state_next = ST_PUT;
                if (op_t'(item_reg.opcode) == OP_READ)
                begin
                    res_next.stat_value = (bin_wide > STAT_MAX) ? '1 : bin_wide[STAT_W-1:0];
                end
                else
                begin
                    hist_we                     = 1'b1;
                    hist_wd                     = (bin_sum > BIN_MAX)
                                                ? BIN_MAX[COUNT_BITS-1:0]
                                                : bin_sum[COUNT_BITS-1:0];
                    hist_vld_next[hist_idx_reg] = 1'b1;
                end
            end

            ST_PUT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.valid            = out_valid_reg;
    assign res.new_age          = out_reg.new_age;
    assign res.set_idle_request = out_reg.set_idle_request;
    assign res.pages_covered    = out_reg.pages_covered;
    assign res.counted          = out_reg.counted;
    assign res.bucket_hit       = out_reg.bucket_hit;
    assign res.stat_value       = out_reg.stat_value;

    a_round_clears_bins: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd_ready && op_t'(cmd.opcode) == OP_ROUND)
        |=> (hist_vld_reg == '0))
        else $error("bins not cleared on new round");

    a_round_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd_ready && op_t'(cmd.opcode) == OP_ROUND)
        |=> (round_reg == $past(round_reg) + ROUND_W'(1)))
        else $error("round counter did not advance");

    a_result_from_put: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg ##1 out_valid_reg) |-> ($past(state_reg) == ST_PUT))
        else $error("result loaded outside the result stage");

    a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUT && out_valid_reg && !res.ready)
        |=> (state_reg == ST_PUT && $stable(out_reg)))
        else $error("pending result overwritten while stalled");

endmodule

@@ sim/idle_page_age_histogram_tb.sv @@
module idle_page_age_histogram_tb
    import iph_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  HALF_PERIOD  = 2;
    localparam int  RESET_CYCLES = 4;
    localparam int  LONG_HOLD    = 300;
    localparam int  STALL_LIMIT  = 20000;
    localparam int  SETTLE       = 20;
    localparam int  GAP_MAX      = 16;
    localparam int  RUN_SCANS    = 270;
    localparam int  RANDOM_CMDS  = 560;
    localparam int  ITEM_W       = $bits(item_t);
    localparam logic [AGE_BITS_DEF-1:0] AGE_MAX = '1;

    typedef struct {
        item_t       it;
        int unsigned gap;
        bit          drain;
        bit          hold;
    } backlog_t;

    logic clk = 1'b0;
    logic rst_n;

    iph_cmd_if cmd_ch ();
    iph_res_if res_ch ();

    idle_page_age_histogram dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    always #(HALF_PERIOD) clk = ~clk;

    logic [AGE_BITS_DEF-1:0] page_age [FRAME_COUNT_DEF];
    logic [STAT_W-1:0]       age_bins [HIST_DEPTH];
    logic [ROUND_W-1:0]      round_ctr;
    logic [INDEX_W-1:0]      hot_pages [8];

    backlog_t cmd_backlog [$];
    res_t     due_results [$];
    backlog_t on_offer;
    bit       offering;
    bit       tx_quiet;
    bit       rx_quiet;
    bit       took;
    int       gap_left;
    int       stall_left;
    int       n_sent;
    int       n_got;
    int       hold_asks;
    int       hold_taken;
    int       err_cnt;
    int       quiet_cycles;
    res_t     want;

    function automatic int age_bucket(input int a);
        if (a >= 240)
        begin
            return 7;
        end
        if (a >= 120)
        begin
            return 6;
        end
        if (a >= 60)
        begin
            return 5;
        end
        if (a >= 30)
        begin
            return 4;
        end
        if (a >= 15)
        begin
            return 3;
        end
        if (a >= 5)
        begin
            return 2;
        end
        if (a >= 2)
        begin
            return 1;
        end
        return 0;
    endfunction

    function automatic res_t age_tracker_step(input item_t it);
        res_t                    r;
        int                      ord;
        int                      b;
        logic [AGE_BITS_DEF-1:0] age;
        logic [INDEX_W-1:0]      shifted;
        logic [2:0]              pr;
        logic                    hit;
        logic                    idle;
        logic                    dropped;
        logic [STAT_W:0]         sum;
        r = RES_DEFAULT;
        case (it.opcode)
            OP_SCAN:
            begin
                if (!it.page_valid)
                begin
                    return r;
                end
                if (!it.on_lru)
                begin
                    page_age[it.page_index] = '0;
                    return r;
                end
                ord = (it.huge_order > MAX_ORDER_DEF) ? MAX_ORDER_DEF : int'(it.huge_order);
                age = page_age[it.page_index];
                idle = 1'b0;
                dropped = 1'b0;
                if (it.idle_bit)
                begin
                    shifted = it.page_index >> ord;
                    pr = shifted[2:0] + round_ctr;
                    if (age == 0)
                    begin
                        hit = pr[0];
                    end
                    else if (age < 4)
                    begin
                        hit = 1'b1;
                    end
                    else if (age < 8)
                    begin
                        hit = pr[0];
                    end
                    else if (age < 16)
                    begin
                        hit = (pr[1:0] == 2'b11);
                    end
                    else
                    begin
                        hit = (pr == 3'b111);
                    end
                    if (hit)
                    begin
                        if (!it.can_pin || !it.still_on_lru)
                        begin
                            dropped = 1'b1;
                        end
                        else
                        begin
                            idle = it.still_idle;
                        end
                    end
                    else if (age != 0)
                    begin
                        idle = 1'b1;
                    end
                end
                if (dropped)
                begin
                    page_age[it.page_index] = '0;
                    return r;
                end
                r.pages_covered = COVER_W'(32'd1 << ord);
                if (idle)
                begin
                    if (age != AGE_MAX)
                    begin
                        age = age + 1'b1;
                    end
                    page_age[it.page_index] = age;
                    b = age_bucket(int'(age));
                    sum = {1'b0, age_bins[it.page_kind * N_BUCKETS + b]} + (33'd1 << ord);
                    age_bins[it.page_kind * N_BUCKETS + b] = sum[STAT_W] ? '1 : sum[STAT_W-1:0];
                    r.new_age = OUT_AGE_W'(age);
                    r.counted = 1'b1;
                    r.bucket_hit = BUCKET_W'(b);
                end
                else
                begin
                    page_age[it.page_index] = '0;
                    r.set_idle_request = it.can_pin & it.still_on_lru;
                end
            end
            OP_ROUND:
            begin
                foreach (age_bins[i])
                begin
                    age_bins[i] = '0;
                end
                round_ctr = round_ctr + 1'b1;
            end
            OP_READ:
            begin
                r.stat_value = age_bins[it.page_kind * N_BUCKETS + it.stat_bucket];
            end
            default:
            begin
                page_age[it.page_index] = '0;
            end
        endcase
        return r;
    endfunction

    function automatic logic chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic item_t scan_cmd(input logic [INDEX_W-1:0] idx, input bit pv, input bit lru,
                                       input bit idl, input bit pin, input bit still_lru,
                                       input bit still_idl, input logic [KIND_W-1:0] kind,
                                       input logic [ORDER_W-1:0] ord);
        item_t it;
        it.opcode       = OP_SCAN;
        it.page_index   = idx;
        it.page_valid   = pv;
        it.on_lru       = lru;
        it.idle_bit     = idl;
        it.can_pin      = pin;
        it.still_on_lru = still_lru;
        it.still_idle   = still_idl;
        it.page_kind    = kind;
        it.huge_order   = ord;
        it.stat_bucket  = BUCKET_W'($urandom);
        return it;
    endfunction

    function automatic item_t op_cmd(input op_t op, input logic [INDEX_W-1:0] idx,
                                     input logic [KIND_W-1:0] kind,
                                     input logic [BUCKET_W-1:0] bkt);
        item_t it;
        it = item_t'(ITEM_W'($urandom));
        it.opcode      = op;
        it.page_index  = idx;
        it.page_kind   = kind;
        it.stat_bucket = bkt;
        return it;
    endfunction

    function automatic item_t random_cmd();
        item_t it;
        int    pick;
        pick = $urandom_range(0, 99);
        it.opcode = (pick < 70) ? OP_SCAN : (pick < 75) ? OP_ROUND :
                    (pick < 90) ? OP_READ : OP_CLEAR;
        it.page_index   = chance(75) ? hot_pages[$urandom_range(0, 7)] : INDEX_W'($urandom);
        it.page_valid   = chance(92);
        it.on_lru       = chance(92);
        it.idle_bit     = chance(85);
        it.can_pin      = chance(90);
        it.still_on_lru = chance(90);
        it.still_idle   = chance(85);
        it.page_kind    = KIND_W'($urandom);
        it.huge_order   = chance(50) ? '0 : ORDER_W'($urandom_range(0, 15));
        it.stat_bucket  = BUCKET_W'($urandom);
        return it;
    endfunction

    function automatic void push_cmd(input item_t it, input bit drain = 1'b0,
                                     input bit hold = 1'b0);
        backlog_t e;
        e.it    = it;
        e.gap   = tx_quiet ? 0 : $urandom_range(0, GAP_MAX);
        e.drain = drain;
        e.hold  = hold;
        cmd_backlog.push_back(e);
    endfunction

    function automatic void check_field(input string name, input longint unsigned exp_v,
                                        input longint unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid        <= 1'b0;
            cmd_ch.opcode       <= '0;
            cmd_ch.page_index   <= '0;
            cmd_ch.page_valid   <= 1'b0;
            cmd_ch.on_lru       <= 1'b0;
            cmd_ch.idle_bit     <= 1'b0;
            cmd_ch.can_pin      <= 1'b0;
            cmd_ch.still_on_lru <= 1'b0;
            cmd_ch.still_idle   <= 1'b0;
            cmd_ch.page_kind    <= '0;
            cmd_ch.huge_order   <= '0;
            cmd_ch.stat_bucket  <= '0;
            hold_asks           <= 0;
            gap_left = 0;
            n_sent = 0;
        end
        else
        begin
            offering = cmd_ch.valid;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                due_results.push_back(age_tracker_step(on_offer.it));
                n_sent++;
                if (on_offer.hold)
                begin
                    hold_asks <= hold_asks + 1;
                end
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    cmd_ch.valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0 && (!cmd_backlog[0].drain || n_got == n_sent))
                begin
                    on_offer = cmd_backlog.pop_front();
                    gap_left = on_offer.gap;
                    cmd_ch.valid        <= 1'b1;
                    cmd_ch.opcode       <= on_offer.it.opcode;
                    cmd_ch.page_index   <= on_offer.it.page_index;
                    cmd_ch.page_valid   <= on_offer.it.page_valid;
                    cmd_ch.on_lru       <= on_offer.it.on_lru;
                    cmd_ch.idle_bit     <= on_offer.it.idle_bit;
                    cmd_ch.can_pin      <= on_offer.it.can_pin;
                    cmd_ch.still_on_lru <= on_offer.it.still_on_lru;
                    cmd_ch.still_idle   <= on_offer.it.still_idle;
                    cmd_ch.page_kind    <= on_offer.it.page_kind;
                    cmd_ch.huge_order   <= on_offer.it.huge_order;
                    cmd_ch.stat_bucket  <= on_offer.it.stat_bucket;
                end
                else
                begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            n_got        <= 0;
            stall_left = 0;
            hold_taken = 0;
            rx_quiet = 1'b0;
        end
        else
        begin
            took = res_ch.valid && res_ch.ready;
            if (took)
            begin
                n_got <= n_got + 1;
                if (due_results.size() == 0)
                begin
                    $error("result item with nothing expected");
                    err_cnt++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("new_age", want.new_age, res_ch.new_age);
                    check_field("set_idle_request", want.set_idle_request,
                                res_ch.set_idle_request);
                    check_field("pages_covered", want.pages_covered, res_ch.pages_covered);
                    check_field("counted", want.counted, res_ch.counted);
                    check_field("bucket_hit", want.bucket_hit, res_ch.bucket_hit);
                    check_field("stat_value", want.stat_value, res_ch.stat_value);
                end
            end
            if (hold_asks != hold_taken)
            begin
                hold_taken = hold_taken + 1;
                stall_left = LONG_HOLD;
            end
            else if (took)
            begin
                if ($urandom_range(0, 49) == 0)
                begin
                    rx_quiet = !rx_quiet;
                end
                stall_left = rx_quiet ? 0 : $urandom_range(0, GAP_MAX);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            res_ch.ready <= (stall_left == 0);
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int                 total;
        logic [INDEX_W-1:0] run_page;
        logic [KIND_W-1:0]  run_kind;

        rst_n = 1'b0;
        err_cnt = 0;
        tx_quiet = 1'b0;
        round_ctr = '0;
        foreach (page_age[i])
        begin
            page_age[i] = '0;
        end
        foreach (age_bins[i])
        begin
            age_bins[i] = '0;
        end
        foreach (hot_pages[i])
        begin
            hot_pages[i] = INDEX_W'($urandom);
        end

        push_cmd(op_cmd(OP_READ, '0, '0, '0));
        push_cmd(scan_cmd(12'd5, 0, 1, 1, 1, 1, 1, 4'd3, 4'd2));
        push_cmd(scan_cmd(12'd6, 1, 0, 1, 1, 1, 1, 4'd3, 4'd0));
        push_cmd(scan_cmd(12'd0, 1, 1, 0, 1, 1, 1, 4'd0, 4'd0));
        push_cmd(scan_cmd(12'd1, 1, 1, 1, 0, 1, 1, 4'd0, 4'd0));
        push_cmd(scan_cmd(12'd1, 1, 1, 1, 1, 0, 1, 4'd0, 4'd0));
        push_cmd(scan_cmd(12'd3, 1, 1, 1, 1, 1, 1, 4'd15, 4'd0));
        push_cmd(scan_cmd(12'd3, 1, 1, 1, 1, 1, 0, 4'd15, 4'd0));
        push_cmd(scan_cmd(12'd4095, 1, 1, 1, 1, 1, 1, 4'd0, 4'd15));
        push_cmd(scan_cmd(12'd8, 1, 1, 1, 1, 0, 1, 4'd9, 4'd9));
        push_cmd(op_cmd(OP_READ, '0, 4'd0, 3'd0));
        push_cmd(op_cmd(OP_READ, '0, 4'd15, 3'd0));
        push_cmd(op_cmd(OP_READ, '1, 4'd15, 3'd7));
        push_cmd(op_cmd(OP_CLEAR, 12'd4095, 4'd0, 3'd0));
        push_cmd(scan_cmd(12'd4095, 1, 1, 1, 1, 1, 1, 4'd0, 4'd9));
        push_cmd(op_cmd(OP_ROUND, '0, '0, '0));
        push_cmd(op_cmd(OP_READ, '0, 4'd0, 3'd0));

        // age one page up through every bucket into saturation
        run_page = INDEX_W'($urandom);
        run_kind = KIND_W'($urandom);
        push_cmd(op_cmd(OP_CLEAR, run_page, '0, '0), 1'b1);
        for (int i = 0; i < RUN_SCANS; i++)
        begin
            if (i % 40 == 0)
            begin
                tx_quiet = chance(50);
            end
            if (i % 20 == 19)
            begin
                push_cmd(op_cmd(OP_READ, INDEX_W'($urandom), run_kind, BUCKET_W'($urandom)));
            end
            else
            begin
                push_cmd(scan_cmd(run_page, 1, 1, 1, 1, 1, 1, run_kind,
                                  ORDER_W'($urandom_range(0, 15))));
            end
        end

        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            if (i % 60 == 0)
            begin
                tx_quiet = chance(40);
            end
            push_cmd(random_cmd(), i == 400, i == 100);
        end
        total = cmd_backlog.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (n_sent < total || due_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);

        if (due_results.size() != 0)
        begin
            $error("%0d expected result items never arrived", due_results.size());
            err_cnt++;
        end
        if (err_cnt == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
